// File: rtl/core/qts_pkg.sv
// shared types, constants and character helpers of the query token scanner
`default_nettype none

package qts_pkg;

    // token length cap for number and identifier tokens
    localparam int MAX_TOKEN_CHARS = 255;

    // word queue between the front and back parts
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    // result slots of one descriptor: held keyword letters, then close, token, close
    localparam int FLUSH_SLOTS = 5;
    localparam int NUM_SLOTS   = FLUSH_SLOTS + 3;
    localparam int SLOT_IDX_W  = $clog2(NUM_SLOTS);
    localparam logic [SLOT_IDX_W-1:0] SLOT_C1 = SLOT_IDX_W'(FLUSH_SLOTS);
    localparam logic [SLOT_IDX_W-1:0] SLOT_T  = SLOT_IDX_W'(FLUSH_SLOTS + 1);
    localparam logic [SLOT_IDX_W-1:0] SLOT_C2 = SLOT_IDX_W'(FLUSH_SLOTS + 2);

    // token kinds
    localparam logic [4:0] KIND_NUMBER  = 5'd0;
    localparam logic [4:0] KIND_IDENT   = 5'd1;
    localparam logic [4:0] KIND_SELECT  = 5'd2;
    localparam logic [4:0] KIND_INSERT  = 5'd3;
    localparam logic [4:0] KIND_UNKNOWN = 5'd17;

    // scanner modes
    typedef enum logic [1:0] {
        MODE_IDLE,
        MODE_NUMBER,
        MODE_IDENT,
        MODE_KEYWORD
    } scan_mode_t;

    // compact description of all results caused by one character
    typedef struct packed {
        logic [2:0] flush_n;
        logic       flush_ins;
        logic       c1_en;
        logic [4:0] c1_kind;
        logic       t_en;
        logic [4:0] t_kind;
        logic [7:0] t_char;
        logic       t_valid;
        logic       t_done;
        logic       c2_en;
        logic [4:0] c2_kind;
    } qts_desc_t;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= "0") && (c <= "9");
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z")) || (c == "_");
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c == " ") || (c == 8'h0D) || (c == 8'h09) || (c == 8'h0A);
    endfunction

    // symbol kinds in order, unknown for anything else
    function automatic logic [4:0] symbol_kind(input logic [7:0] c);
        logic [4:0] k;
        unique case (c)
            "+":     k = 5'd4;
            "-":     k = 5'd5;
            "*":     k = 5'd6;
            "!":     k = 5'd7;
            "(":     k = 5'd8;
            ")":     k = 5'd9;
            "/":     k = 5'd10;
            "=":     k = 5'd11;
            "?":     k = 5'd12;
            ",":     k = 5'd13;
            ".":     k = 5'd14;
            "&":     k = 5'd15;
            "|":     k = 5'd16;
            default: k = KIND_UNKNOWN;
        endcase
        return k;
    endfunction

    // keyword letter by position: first letter, then the five tail letters
    function automatic logic [7:0] kw_letter(input logic ins, input logic [2:0] idx);
        logic [7:0] ch;
        unique case (idx)
            3'd0:    ch = ins ? "I" : "S";
            3'd1:    ch = ins ? "N" : "E";
            3'd2:    ch = ins ? "S" : "L";
            3'd3:    ch = ins ? "E" : "E";
            3'd4:    ch = ins ? "R" : "C";
            3'd5:    ch = "T";
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/qts_front.sv
// front part: accepts characters, tracks scanner state and builds result descriptors
`default_nettype none

module qts_front (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic [7:0]        s_character,
    input  wire logic              s_end_of_query,
    input  wire logic              s_valid,
    output logic                   s_ready,
    output qts_pkg::qts_desc_t     desc,
    output logic                   desc_push,
    input  wire logic              desc_ready
);
    import qts_pkg::*;

    scan_mode_t mode_reg, mode_next;
    logic [7:0] len_reg, len_next;
    logic       ins_reg, ins_next;
    logic [2:0] matched_reg, matched_next;

    logic       accept;
    qts_desc_t  d;
    logic       common;
    logic       start_en;
    logic       app_en;
    scan_mode_t app_mode;
    logic [7:0] app_len;
    logic [8:0] len1;
    logic       kw_start;
    logic [2:0] held;
    scan_mode_t eff_mode;
    logic [7:0] eff_len;

    assign s_ready = desc_ready;
    assign accept  = s_valid && desc_ready;

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg    <= MODE_IDLE;
            len_reg     <= '0;
            ins_reg     <= 1'b0;
            matched_reg <= '0;
        end else if (accept) begin
            mode_reg    <= mode_next;
            len_reg     <= len_next;
            ins_reg     <= ins_next;
            matched_reg <= matched_next;
        end
    end

    // next state and descriptor for the offered character
    always_comb begin
        d            = '0;
        mode_next    = mode_reg;
        len_next     = len_reg;
        ins_next     = ins_reg;
        matched_next = matched_reg;
        eff_mode     = mode_reg;
        eff_len      = len_reg;
        common       = 1'b1;
        start_en     = 1'b0;
        app_en       = 1'b0;
        app_mode     = MODE_IDENT;
        app_len      = '0;
        len1         = '0;
        kw_start     = 1'b0;
        held         = '0;

        // keyword prefix match
        if (mode_reg == MODE_KEYWORD) begin
            held = (matched_reg < 3'd5) ? matched_reg : 3'd4;
            if ((matched_reg < 3'd5) &&
                (s_character == kw_letter(ins_reg, matched_reg + 3'd1))) begin
                common = 1'b0;
                if (matched_reg == 3'd4) begin
                    d.t_en       = 1'b1;
                    d.t_kind     = ins_reg ? KIND_INSERT : KIND_SELECT;
                    d.t_done     = 1'b1;
                    mode_next    = MODE_IDLE;
                    matched_next = '0;
                    len_next     = '0;
                end else begin
                    matched_next = matched_reg + 3'd1;
                end
            end else begin
                // failed match: held letters go out as an identifier
                d.flush_n    = held + 3'd1;
                d.flush_ins  = ins_reg;
                eff_mode     = MODE_IDENT;
                eff_len      = {5'd0, held} + 8'd1;
                matched_next = '0;
            end
        end

        // extend or close the pending token
        if (common) begin
            unique case (eff_mode)
                MODE_NUMBER: begin
                    if (is_digit(s_character) || (s_character == ".")) begin
                        app_en   = 1'b1;
                        app_mode = MODE_NUMBER;
                        app_len  = eff_len;
                    end else begin
                        d.c1_en   = 1'b1;
                        d.c1_kind = KIND_NUMBER;
                        start_en  = 1'b1;
                    end
                end
                MODE_IDENT: begin
                    if (is_alpha(s_character) || is_digit(s_character)) begin
                        app_en   = 1'b1;
                        app_mode = MODE_IDENT;
                        app_len  = eff_len;
                    end else begin
                        d.c1_en   = 1'b1;
                        d.c1_kind = KIND_IDENT;
                        start_en  = 1'b1;
                    end
                end
                MODE_IDLE:    start_en = 1'b1;
                MODE_KEYWORD: start_en = 1'b0;
            endcase
        end

        // start a new token
        if (start_en) begin
            mode_next = MODE_IDLE;
            len_next  = '0;
            if (is_space(s_character)) begin
                app_en = 1'b0;
            end else if (is_digit(s_character)) begin
                app_en   = 1'b1;
                app_mode = MODE_NUMBER;
            end else if (is_alpha(s_character)) begin
                if ((s_character == "S") || (s_character == "I")) begin
                    mode_next    = MODE_KEYWORD;
                    ins_next     = (s_character == "I");
                    matched_next = '0;
                    kw_start     = 1'b1;
                end else begin
                    app_en   = 1'b1;
                    app_mode = MODE_IDENT;
                end
            end else begin
                d.t_en   = 1'b1;
                d.t_kind = symbol_kind(s_character);
                d.t_done = 1'b1;
                if (d.t_kind == KIND_UNKNOWN) begin
                    d.t_char  = s_character;
                    d.t_valid = 1'b1;
                end
            end
        end

        // append a payload character, closing at the length cap
        if (app_en) begin
            d.t_en    = 1'b1;
            d.t_kind  = (app_mode == MODE_NUMBER) ? KIND_NUMBER : KIND_IDENT;
            d.t_char  = s_character;
            d.t_valid = 1'b1;
            len1      = {1'b0, app_len} + 9'd1;
            if (len1 >= 9'(MAX_TOKEN_CHARS)) begin
                d.c2_en   = 1'b1;
                d.c2_kind = d.t_kind;
                mode_next = MODE_IDLE;
                len_next  = '0;
            end else begin
                mode_next = app_mode;
                len_next  = len1[7:0];
            end
        end

        // end of query closes whatever is pending
        if (s_end_of_query) begin
            unique case (mode_next)
                MODE_KEYWORD: begin
                    d.c2_en   = 1'b1;
                    d.c2_kind = KIND_IDENT;
                    if (kw_start) begin
                        d.t_en    = 1'b1;
                        d.t_kind  = KIND_IDENT;
                        d.t_char  = s_character;
                        d.t_valid = 1'b1;
                    end else begin
                        d.flush_n   = matched_next + 3'd1;
                        d.flush_ins = ins_next;
                    end
                end
                MODE_NUMBER, MODE_IDENT: begin
                    d.c2_en   = 1'b1;
                    d.c2_kind = (mode_next == MODE_NUMBER) ? KIND_NUMBER : KIND_IDENT;
                end
                MODE_IDLE: d.c2_en = d.c2_en;
            endcase
            mode_next    = MODE_IDLE;
            len_next     = '0;
            matched_next = '0;
        end
    end

    assign desc      = d;
    assign desc_push = accept && ((d.flush_n != 3'd0) || d.c1_en || d.t_en || d.c2_en);

    // checks
    a_kw_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (mode_reg == MODE_KEYWORD) |-> (matched_reg < 3'd5))
        else $error("keyword match count out of range");
    a_len_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        ((mode_reg == MODE_NUMBER) || (mode_reg == MODE_IDENT)) |->
        ({1'b0, len_reg} < 9'(MAX_TOKEN_CHARS)))
        else $error("token length passed the cap");
    a_end_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_end_of_query) |=> ((mode_reg == MODE_IDLE) && (len_reg == 8'd0)))
        else $error("scanner not idle after end of query");

endmodule

`default_nettype wire

// File: rtl/core/qts_queue.sv
// short descriptor queue between the front and back parts
`default_nettype none

module qts_queue (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              push,
    input  wire qts_pkg::qts_desc_t in_desc,
    output logic                   in_ready,
    output logic                   out_valid,
    output qts_pkg::qts_desc_t     out_desc,
    input  wire logic              pop
);
    import qts_pkg::*;

    qts_desc_t               entry_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [QUEUE_CNT_W-1:0]  count_reg;

    assign in_ready  = (count_reg != QUEUE_CNT_W'(QUEUE_DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_desc  = entry_reg[rd_ptr_reg];

    // storage, no reset needed
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= in_desc;
        end
    end

    // pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ?
                              '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ?
                              '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // checks
    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> (count_reg != '0))
        else $error("pop from empty queue");

endmodule

`default_nettype wire

// File: rtl/core/qts_back.sv
// back part: expands descriptors into result words through an output register
`default_nettype none

module qts_back (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              q_valid,
    input  wire qts_pkg::qts_desc_t q_desc,
    output logic                   q_pop,
    output logic [4:0]             m_token_kind,
    output logic [7:0]             m_payload_char,
    output logic                   m_char_valid,
    output logic                   m_token_done,
    output logic                   m_run_last,
    output logic                   m_valid,
    input  wire logic              m_ready
);
    import qts_pkg::*;

    qts_desc_t              cur_reg, cur_next;
    logic [NUM_SLOTS-1:0]   mask_reg, mask_next;
    logic [NUM_SLOTS-1:0]   rest;
    logic [SLOT_IDX_W-1:0]  idx;
    logic                   out_free;
    logic                   emit;

    logic                   valid_reg, valid_next;
    logic [4:0]             kind_reg, kind_next;
    logic [7:0]             char_reg, char_next;
    logic                   cval_reg, cval_next;
    logic                   done_reg, done_next;
    logic                   last_reg, last_next;

    function automatic logic [NUM_SLOTS-1:0] slot_mask(input qts_desc_t dd);
        logic [NUM_SLOTS-1:0] m;
        m = '0;
        for (int k = 0; k < FLUSH_SLOTS; k++) begin
            m[k] = (3'(k) < dd.flush_n);
        end
        m[SLOT_C1] = dd.c1_en;
        m[SLOT_T]  = dd.t_en;
        m[SLOT_C2] = dd.c2_en;
        return m;
    endfunction

    // pick the lowest pending slot
    always_comb begin
        idx = '0;
        for (int k = NUM_SLOTS - 1; k >= 0; k--) begin
            if (mask_reg[k]) begin
                idx = SLOT_IDX_W'(k);
            end
        end
    end

    assign rest     = mask_reg & (mask_reg - 1'b1);
    assign out_free = !valid_reg || m_ready;
    assign emit     = out_free && (mask_reg != '0);
    assign q_pop    = q_valid && ((mask_reg == '0) || (emit && (rest == '0)));

    // result word for the chosen slot and next sequencer state
    always_comb begin
        cur_next   = cur_reg;
        mask_next  = mask_reg;
        valid_next = valid_reg && !m_ready;
        kind_next  = kind_reg;
        char_next  = char_reg;
        cval_next  = cval_reg;
        done_next  = done_reg;
        last_next  = last_reg;

        if (emit) begin
            valid_next = 1'b1;
            last_next  = (rest == '0);
            mask_next  = rest;
            if (idx < SLOT_C1) begin
                kind_next = KIND_IDENT;
                char_next = kw_letter(cur_reg.flush_ins, 3'(idx));
                cval_next = 1'b1;
                done_next = 1'b0;
            end else begin
                unique case (idx)
                    SLOT_C1: begin
                        kind_next = cur_reg.c1_kind;
                        char_next = 8'h00;
                        cval_next = 1'b0;
                        done_next = 1'b1;
                    end
                    SLOT_T: begin
                        kind_next = cur_reg.t_kind;
                        char_next = cur_reg.t_char;
                        cval_next = cur_reg.t_valid;
                        done_next = cur_reg.t_done;
                    end
                    default: begin
                        kind_next = cur_reg.c2_kind;
                        char_next = 8'h00;
                        cval_next = 1'b0;
                        done_next = 1'b1;
                    end
                endcase
            end
        end

        if (q_pop) begin
            cur_next  = q_desc;
            mask_next = slot_mask(q_desc);
        end
    end

    // sequencer and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mask_reg  <= '0;
            valid_reg <= 1'b0;
        end else begin
            mask_reg  <= mask_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg  <= cur_next;
        kind_reg <= kind_next;
        char_reg <= char_next;
        cval_reg <= cval_next;
        done_reg <= done_next;
        last_reg <= last_next;
    end

    assign m_valid        = valid_reg;
    assign m_token_kind   = kind_reg;
    assign m_payload_char = char_reg;
    assign m_char_valid   = cval_reg;
    assign m_token_done   = done_reg;
    assign m_run_last     = last_reg;

    // checks
    a_last_marks_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (emit && (rest == '0)) |=> (m_valid && m_run_last))
        else $error("final word of an item lacks run_last");

endmodule

`default_nettype wire

// File: rtl/core/query_token_scanner_unit.sv
// top level of the query token scanner
`default_nettype none

// Streaming query lexer. One raw byte is taken per s_ word; whitespace is
// skipped, numbers and identifiers stream out one payload word per character
// followed by an end marker (capped at 255 characters), uppercase SELECT and
// INSERT prefixes become keyword tokens, thirteen symbols become single tokens
// and any other byte an unknown token. s_end_of_query closes what is pending.
// Timing: the front part takes one character per clock while its two-word
// descriptor queue has room; the back part sends one result word per clock
// from its output register while m_ready is high. Every item produces result
// words at the back: one for most characters, none for whitespace or a
// keyword letter that is held, up to seven when a held keyword prefix is
// flushed. The back part's one-word-per-clock output register sets the
// sustained rate. With the back part idle, an accepted word is stored in the
// descriptor queue, loaded into the sequencer and then written to the output
// register, where m_valid rises.
module query_token_scanner_unit (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic [7:0] s_character,
    input  wire logic       s_end_of_query,
    input  wire logic       s_valid,
    output logic            s_ready,
    output logic [4:0]      m_token_kind,
    output logic [7:0]      m_payload_char,
    output logic            m_char_valid,
    output logic            m_token_done,
    output logic            m_run_last,
    output logic            m_valid,
    input  wire logic       m_ready
);
    import qts_pkg::*;

    qts_desc_t front_desc;
    qts_desc_t back_desc;
    logic      desc_push;
    logic      desc_ready;
    logic      q_valid;
    logic      q_pop;

    // character classification and scanner state
    qts_front u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_character    (s_character),
        .s_end_of_query (s_end_of_query),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .desc           (front_desc),
        .desc_push      (desc_push),
        .desc_ready     (desc_ready)
    );

    // descriptor queue
    qts_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (desc_push),
        .in_desc   (front_desc),
        .in_ready  (desc_ready),
        .out_valid (q_valid),
        .out_desc  (back_desc),
        .pop       (q_pop)
    );

    // result sequencer
    qts_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .q_valid        (q_valid),
        .q_desc         (back_desc),
        .q_pop          (q_pop),
        .m_token_kind   (m_token_kind),
        .m_payload_char (m_payload_char),
        .m_char_valid   (m_char_valid),
        .m_token_done   (m_token_done),
        .m_run_last     (m_run_last),
        .m_valid        (m_valid),
        .m_ready        (m_ready)
    );

endmodule

`default_nettype wire

// File: tb/query_token_scanner_checker.sv
// checker for the query token scanner: predicts each result word and compares it
module query_token_scanner_checker (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic [7:0] s_character,
    input  wire logic       s_end_of_query,
    input  wire logic       s_valid,
    input  wire logic       s_ready,
    input  wire logic [4:0] m_token_kind,
    input  wire logic [7:0] m_payload_char,
    input  wire logic       m_char_valid,
    input  wire logic       m_token_done,
    input  wire logic       m_run_last,
    input  wire logic       m_valid,
    input  wire logic       m_ready,
    output int              fail_count,
    output int              pending_words
);
    import qts_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [4:0] KIND_SYMBOL_FIRST  = 5'd4;
    localparam int         MAX_WORDS_PER_CHAR = 7;
    localparam int         KEYWORD_TAIL_LEN   = 5;

    typedef struct packed {
        logic [4:0] kind;
        logic [7:0] ch;
        logic       valid;
        logic       done;
        logic       last;
    } token_word_t;

    // words of the character being scanned, and all words still owed by the block
    token_word_t char_words[$];
    token_word_t expected_words[$];

    // scanner state as predicted
    scan_mode_t  mode;
    logic [7:0]  tok_len;
    logic        kw_ins;
    logic [2:0]  kw_matched;

    initial begin
        fail_count    = 0;
        pending_words = 0;
    end

    function automatic logic byte_is_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic byte_is_word(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
    endfunction

    function automatic logic byte_is_blank(input logic [7:0] c);
        return c == " " || c == 8'h0D || c == 8'h09 || c == 8'h0A;
    endfunction

    // symbol kinds follow the order of the symbol list, anything else is unknown
    function automatic logic [4:0] symbol_code(input logic [7:0] c);
        string set;
        set = "+-*!()/=?,.&|";
        for (int k = 0; k < set.len(); k++) begin
            if (set[k] == c) begin
                return KIND_SYMBOL_FIRST + 5'(k);
            end
        end
        return KIND_UNKNOWN;
    endfunction

    function automatic logic [7:0] keyword_tail(input logic ins, input int idx);
        string tail;
        tail = ins ? "NSERT" : "ELECT";
        return tail[idx];
    endfunction

    task automatic emit(input logic [4:0] kind, input logic [7:0] ch,
                        input logic valid, input logic done);
        token_word_t w;
        w = '{kind: kind, ch: ch, valid: valid, done: done, last: 1'b0};
        if (char_words.size() < MAX_WORDS_PER_CHAR) begin
            char_words.push_back(w);
        end
    endtask

    function automatic logic [4:0] open_kind();
        return mode == MODE_NUMBER ? KIND_NUMBER : KIND_IDENT;
    endfunction

    task automatic close_tok();
        emit(open_kind(), 8'h00, 1'b0, 1'b1);
        mode    = MODE_IDLE;
        tok_len = '0;
    endtask

    // append one payload character, closing the token once it reaches the cap
    task automatic add_char(input logic [7:0] c);
        emit(open_kind(), c, 1'b1, 1'b0);
        tok_len = tok_len + 8'd1;
        if (tok_len >= MAX_TOKEN_CHARS) begin
            close_tok();
        end
    endtask

    // held keyword letters turn into an identifier
    task automatic flush_held();
        int held;
        held       = (kw_matched < KEYWORD_TAIL_LEN) ? int'(kw_matched) : 4;
        mode       = MODE_IDENT;
        tok_len    = '0;
        kw_matched = '0;
        add_char(kw_ins ? 8'h49 : 8'h53);
        for (int k = 0; k < held && mode == MODE_IDENT; k++) begin
            add_char(keyword_tail(kw_ins, k));
        end
    endtask

    task automatic begin_token(input logic [7:0] c);
        logic [4:0] sym;
        tok_len = '0;
        if (byte_is_blank(c)) begin
            return;
        end
        if (byte_is_digit(c)) begin
            mode = MODE_NUMBER;
            add_char(c);
            return;
        end
        if (byte_is_word(c)) begin
            if (c == "S" || c == "I") begin
                mode       = MODE_KEYWORD;
                kw_ins     = (c == "I");
                kw_matched = '0;
            end else begin
                mode = MODE_IDENT;
                add_char(c);
            end
            return;
        end
        sym = symbol_code(c);
        if (sym != KIND_UNKNOWN) begin
            emit(sym, 8'h00, 1'b0, 1'b1);
        end else begin
            emit(KIND_UNKNOWN, c, 1'b1, 1'b1);
        end
    endtask

    task automatic scan_char(input logic [7:0] c);
        // keyword match in progress: extend it, complete it or give it up
        if (mode == MODE_KEYWORD) begin
            if (kw_matched < KEYWORD_TAIL_LEN && keyword_tail(kw_ins, kw_matched) == c) begin
                kw_matched = kw_matched + 3'd1;
                if (kw_matched >= KEYWORD_TAIL_LEN) begin
                    emit(kw_ins ? KIND_INSERT : KIND_SELECT, 8'h00, 1'b0, 1'b1);
                    mode       = MODE_IDLE;
                    kw_matched = '0;
                    tok_len    = '0;
                end
                return;
            end
            flush_held();
        end
        // extend the open token or close it
        if (mode == MODE_NUMBER) begin
            if (byte_is_digit(c) || c == ".") begin
                add_char(c);
                return;
            end
            close_tok();
        end else if (mode == MODE_IDENT) begin
            if (byte_is_word(c) || byte_is_digit(c)) begin
                add_char(c);
                return;
            end
            close_tok();
        end
        begin_token(c);
    endtask

    task automatic predict_char(input logic [7:0] c, input logic eoq);
        token_word_t w;
        char_words.delete();
        scan_char(c);
        // query end closes whatever is pending
        if (eoq) begin
            if (mode == MODE_KEYWORD) begin
                flush_held();
            end
            if (mode == MODE_NUMBER || mode == MODE_IDENT) begin
                close_tok();
            end
            mode       = MODE_IDLE;
            tok_len    = '0;
            kw_matched = '0;
        end
        if (char_words.size() > 0) begin
            w      = char_words.pop_back();
            w.last = 1'b1;
            char_words.push_back(w);
        end
        foreach (char_words[k]) begin
            expected_words.push_back(char_words[k]);
        end
    endtask

    task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    task automatic check_word();
        token_word_t want;
        if (expected_words.size() == 0) begin
            $error("unexpected result word: token_kind %0d payload_char %0d",
                   m_token_kind, m_payload_char);
            fail_count++;
            return;
        end
        want = expected_words.pop_front();
        check_field("token_kind", 8'(want.kind), 8'(m_token_kind));
        check_field("payload_char", want.ch, m_payload_char);
        check_field("char_valid", 8'(want.valid), 8'(m_char_valid));
        check_field("token_done", 8'(want.done), 8'(m_token_done));
        check_field("run_last", 8'(want.last), 8'(m_run_last));
    endtask

    // watch both channels at each rising edge
    always @(posedge aclk) begin
        if (!aresetn) begin
            mode       = MODE_IDLE;
            tok_len    = '0;
            kw_ins     = 1'b0;
            kw_matched = '0;
            expected_words.delete();
        end else begin
            if (m_valid && m_ready) begin
                check_word();
            end
            if (s_valid && s_ready) begin
                predict_char(s_character, s_end_of_query);
            end
        end
        pending_words = expected_words.size();
    end

endmodule

// File: tb/query_token_scanner_unit_tb.sv
// testbench top of the query token scanner: stimulus, receiver stalls and verdict
module query_token_scanner_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    logic       aclk           = 1'b0;
    logic       aresetn        = 1'b0;
    logic [7:0] s_character    = 8'h00;
    logic       s_end_of_query = 1'b0;
    logic       s_valid        = 1'b0;
    logic       s_ready;
    logic [4:0] m_token_kind;
    logic [7:0] m_payload_char;
    logic       m_char_valid;
    logic       m_token_done;
    logic       m_run_last;
    logic       m_valid;
    logic       m_ready        = 1'b0;

    int fail_count;
    int pending_words;

    int sender_idle_pct    = 0;
    int receiver_stall_pct = 0;
    int items_sent         = 0;

    logic [7:0] token_bytes[$];

    localparam int MAX_TOKEN_CHARS_TB = qts_pkg::MAX_TOKEN_CHARS;

    query_token_scanner_unit dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_character    (s_character),
        .s_end_of_query (s_end_of_query),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .m_token_kind   (m_token_kind),
        .m_payload_char (m_payload_char),
        .m_char_valid   (m_char_valid),
        .m_token_done   (m_token_done),
        .m_run_last     (m_run_last),
        .m_valid        (m_valid),
        .m_ready        (m_ready)
    );

    query_token_scanner_checker checker_i (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_character    (s_character),
        .s_end_of_query (s_end_of_query),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .m_token_kind   (m_token_kind),
        .m_payload_char (m_payload_char),
        .m_char_valid   (m_char_valid),
        .m_token_done   (m_token_done),
        .m_run_last     (m_run_last),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .fail_count     (fail_count),
        .pending_words  (pending_words)
    );

    // 2 ns clock
    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // receiver stalls at random
    always @(negedge aclk) begin
        m_ready = ($urandom_range(0, 99) >= receiver_stall_pct);
    end

    // overall time limit
    initial begin
        #1_000_000;
        $display("Regression FAIL");
        $finish;
    end

    function automatic logic [7:0] pick_from(input string set);
        return set[$urandom_range(0, set.len() - 1)];
    endfunction

    function automatic logic [7:0] rand_word_char();
        return pick_from("ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz_");
    endfunction

    function automatic logic [7:0] rand_alnum();
        return pick_from("ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz_0123456789");
    endfunction

    function automatic logic [7:0] rand_digit();
        return pick_from("0123456789");
    endfunction

    function automatic logic [7:0] rand_blank();
        return pick_from(" \r\t\n");
    endfunction

    // offer one word, after a random idle gap, and hold it until taken
    task automatic send_char(input logic [7:0] c, input logic eoq);
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid        = 1'b1;
        s_character    = c;
        s_end_of_query = eoq;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
        if (!(c == " " || c == 8'h0D || c == 8'h09 || c == 8'h0A)) begin
            items_sent++;
        end
    endtask

    task automatic send_text(input string txt, input logic eoq_at_end);
        for (int k = 0; k < txt.len(); k++) begin
            send_char(txt[k], eoq_at_end && k == txt.len() - 1);
        end
    endtask

    task automatic send_token_bytes(input logic eoq_at_end);
        foreach (token_bytes[k]) begin
            send_char(token_bytes[k], eoq_at_end && k == token_bytes.size() - 1);
        end
    endtask

    // sender holds off until every expected word has come back
    task automatic wait_drained();
        s_valid = 1'b0;
        while (pending_words != 0) begin
            @(negedge aclk);
        end
    endtask

    // one random token, mostly well formed, some noise and broken keywords
    task automatic send_random_token();
        string kw;
        int    pick;
        int    n;
        logic  eoq;
        pick = $urandom_range(0, 15);
        eoq  = ($urandom_range(0, 7) == 0);
        token_bytes.delete();
        case (pick)
            0, 1, 2: begin
                kw = $urandom_range(0, 1) ? "SELECT" : "INSERT";
                for (int k = 0; k < 6; k++) token_bytes.push_back(kw[k]);
                n = $urandom_range(0, 3);
                for (int k = 0; k < n; k++) token_bytes.push_back(rand_alnum());
                send_token_bytes(eoq);
            end
            3, 4: begin
                // keyword prefix cut short by an arbitrary byte
                kw = $urandom_range(0, 1) ? "SELECT" : "INSERT";
                n  = $urandom_range(1, 5);
                for (int k = 0; k < n; k++) token_bytes.push_back(kw[k]);
                send_token_bytes(1'b0);
                send_char(8'($urandom_range(0, 255)), eoq);
            end
            5, 6, 7: begin
                token_bytes.push_back(rand_word_char());
                n = $urandom_range(0, 7);
                for (int k = 0; k < n; k++) token_bytes.push_back(rand_alnum());
                send_token_bytes(eoq);
            end
            8, 9: begin
                token_bytes.push_back(rand_digit());
                n = $urandom_range(0, 6);
                for (int k = 0; k < n; k++) begin
                    token_bytes.push_back($urandom_range(0, 3) == 0 ? 8'h2E : rand_digit());
                end
                send_token_bytes(eoq);
            end
            10, 11: send_char(pick_from("+-*!()/=?,.&|"), eoq);
            12:     send_char(8'($urandom_range(0, 255)), eoq);
            13:     send_char($urandom_range(0, 1) ? 8'($urandom_range(128, 255)) : 8'h00, eoq);
            default: begin
                n = $urandom_range(1, 3);
                for (int k = 0; k < n; k++) send_char(rand_blank(), eoq && k == n - 1);
            end
        endcase
        if ($urandom_range(0, 2) == 0) begin
            send_char(rand_blank(), 1'b0);
        end
    endtask

    // a token that runs into the length cap
    task automatic send_long_token(input logic is_number);
        token_bytes.delete();
        if (is_number) begin
            for (int k = 0; k < MAX_TOKEN_CHARS_TB; k++) token_bytes.push_back(rand_digit());
            token_bytes.push_back(8'h2E);
        end else begin
            for (int k = 0; k < MAX_TOKEN_CHARS_TB + 5; k++) token_bytes.push_back(rand_alnum());
            token_bytes[0] = 8'h71;
        end
        send_token_bytes(1'b0);
        send_char(8'h20, 1'b1);
    endtask

    task automatic run_phase(input int idle_pct, input int stall_pct, input int target);
        int first;
        sender_idle_pct    = idle_pct;
        receiver_stall_pct = stall_pct;
        first              = items_sent;
        while (items_sent - first < target) begin
            send_random_token();
        end
    endtask

    initial begin
        // hold reset, then release it on a falling edge
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // directed words: keywords, broken keyword, query end mid-keyword, extremes, a number, symbols, whitespace
        send_text("INSERTx", 1'b1);
        send_text("SELX", 1'b0);
        send_text("IN", 1'b1);
        send_char(8'h00, 1'b0);
        send_char(8'hFF, 1'b0);
        send_text("9.+-*!()/=?,.&|", 1'b0);
        send_text(" \r\t\n", 1'b1);

        // random phases with different sender idling and receiver stalls, plus long tokens
        run_phase(0, 0, 25);
        send_long_token(1'b1);
        run_phase(69, 0, 25);
        wait_drained();
        run_phase(0, 69, 25);
        send_long_token(1'b0);
        run_phase(14, 14, 25);

        // drain and let the block settle
        wait_drained();
        repeat (20) @(negedge aclk);
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
